>>> src/tscc_pkg.sv
// Shared types, constants and command formatting for the throttle status to cab command core.
`default_nettype none

package tscc_pkg;

    localparam int THROTTLE_ENTRIES_DEF = 256;
    localparam int MASK_W = 6;

    localparam logic [15:0] ADDR_MAX        = 16'd9999;
    localparam logic [15:0] XN_SHORT_MAX    = 16'd99;
    localparam logic [15:0] XN_LONG_FLAG    = 16'hC000;
    localparam logic [15:0] CAB_SHORT_MAX   = 16'd127;
    localparam logic [15:0] CAB_SHORT_BASE  = 16'h2780;
    localparam logic [15:0] CAB_SHORT_CLAMP = 16'h27FF;
    localparam logic [15:0] CAB_LONG_CLAMP  = 16'h270F;

    localparam logic [7:0] XN_HEADER    = 8'hE4;
    localparam logic [7:0] XN_SPEED     = 8'h13;
    localparam logic [7:0] XN_GRP1      = 8'h20;
    localparam logic [7:0] XN_GRP2      = 8'h21;
    localparam logic [7:0] XN_GRP3      = 8'h22;
    localparam logic [7:0] XN_GRP4      = 8'h23;
    localparam logic [7:0] XN_GRP5      = 8'h28;
    localparam logic [7:0] CAB_GRP1     = 8'h07;
    localparam logic [7:0] CAB_GRP2     = 8'h08;
    localparam logic [7:0] CAB_GRP3     = 8'h09;
    localparam logic [7:0] CAB_GRP4     = 8'h15;
    localparam logic [7:0] CAB_GRP5     = 8'h16;
    localparam logic [7:0] CAB_ESTOP_FWD = 8'h06;
    localparam logic [7:0] CAB_ESTOP_REV = 8'h05;
    localparam logic [7:0] CAB_SPEED_FWD = 8'h04;
    localparam logic [7:0] CAB_SPEED_REV = 8'h03;
    localparam logic [6:0] STEP_ESTOP    = 7'd1;

    localparam logic [2:0] LEN_CAB = 3'd4;
    localparam logic [2:0] LEN_XN  = 3'd5;

    typedef enum logic [2:0] {
        SEL_SPEED = 3'd0,
        SEL_GRP1  = 3'd1,
        SEL_GRP2  = 3'd2,
        SEL_GRP3  = 3'd3,
        SEL_GRP4  = 3'd4,
        SEL_GRP5  = 3'd5
    } cmd_sel_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  sd;
        logic [4:0]  g1;
        logic [3:0]  g2;
        logic [3:0]  g3;
        logic [7:0]  g4;
        logic [7:0]  g5;
    } rec_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [2:0] len;
    } cmd_t;

    function automatic logic [15:0] translate_addr(input logic [15:0] raw, input logic xn);
        logic [15:0] a;
        a = raw;
        if (xn) begin
            a = {1'b0, raw[14:0]};
            if (a > ADDR_MAX) begin
                a = ADDR_MAX;
            end
            if (a > XN_SHORT_MAX) begin
                a = a | XN_LONG_FLAG;
            end
        end else if (raw[15]) begin
            a = {1'b0, raw[14:0]};
            a = (a > CAB_SHORT_MAX) ? CAB_SHORT_CLAMP : a + CAB_SHORT_BASE;
        end else if (raw > ADDR_MAX) begin
            a = CAB_LONG_CLAMP;
        end
        return a;
    endfunction

    function automatic rec_t make_rec(input logic [15:0] raw, input logic [7:0] sd,
                                      input logic [28:0] f, input logic xn);
        rec_t r;
        r.addr = translate_addr(raw, xn);
        r.sd   = sd;
        r.g1   = {f[0], f[4:1]};
        r.g2   = f[8:5];
        r.g3   = f[12:9];
        r.g4   = f[20:13];
        r.g5   = f[28:21];
        return r;
    endfunction

    function automatic cmd_t build_cmd(input cmd_sel_t sel, input rec_t r, input logic xn);
        cmd_t c;
        logic [7:0] ah;
        logic [7:0] al;
        logic [7:0] gval;
        logic [7:0] xcode;
        logic [7:0] ccode;
        logic [6:0] step;
        ah = xn ? r.addr[15:8] : {1'b0, r.addr[13:7]};
        al = xn ? r.addr[7:0]  : {1'b0, r.addr[6:0]};
        step = r.sd[6:0];
        unique case (sel)
            SEL_GRP1: begin gval = {3'd0, r.g1}; xcode = XN_GRP1; ccode = CAB_GRP1; end
            SEL_GRP2: begin gval = {4'd0, r.g2}; xcode = XN_GRP2; ccode = CAB_GRP2; end
            SEL_GRP3: begin gval = {4'd0, r.g3}; xcode = XN_GRP3; ccode = CAB_GRP3; end
            SEL_GRP4: begin gval = r.g4;         xcode = XN_GRP4; ccode = CAB_GRP4; end
            SEL_GRP5: begin gval = r.g5;         xcode = XN_GRP5; ccode = CAB_GRP5; end
            default:  begin gval = r.sd;         xcode = XN_SPEED; ccode = CAB_SPEED_REV; end
        endcase
        if (xn) begin
            c.b0  = XN_HEADER;
            c.b1  = xcode;
            c.b2  = ah;
            c.b3  = al;
            c.b4  = gval;
            c.len = LEN_XN;
        end else begin
            c.b0  = ah;
            c.b1  = al;
            c.b4  = 8'd0;
            c.len = LEN_CAB;
            if (sel != SEL_SPEED) begin
                c.b2 = ccode;
                c.b3 = gval;
            end else if (step == STEP_ESTOP) begin
                c.b2 = r.sd[7] ? CAB_ESTOP_FWD : CAB_ESTOP_REV;
                c.b3 = 8'd0;
            end else begin
                c.b2 = r.sd[7] ? CAB_SPEED_FWD : CAB_SPEED_REV;
                c.b3 = (step != 7'd0) ? {1'b0, step - 7'd1} : 8'd0;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/tscc_cache.sv
// Per-throttle record memory with entry valid bits and same-cycle write forwarding.
`default_nettype none

module tscc_cache #(
    parameter int THROTTLE_ENTRIES = tscc_pkg::THROTTLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(THROTTLE_ENTRIES)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output tscc_pkg::rec_t        rd_rec,
    output logic                  rd_hit,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire tscc_pkg::rec_t   wr_rec
);

    tscc_pkg::rec_t mem [THROTTLE_ENTRIES];
    logic [THROTTLE_ENTRIES-1:0] valid_reg;
    logic [THROTTLE_ENTRIES-1:0] valid_next;
    tscc_pkg::rec_t rd_data_reg;
    tscc_pkg::rec_t fwd_rec_reg;
    logic fwd_reg;
    logic fwd_next;
    logic hit_reg;
    logic hit_next;
    logic same;

    assign same = wr_en && (wr_idx == rd_idx);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_rec;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
            fwd_rec_reg <= wr_rec;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
        fwd_next = fwd_reg;
        hit_next = hit_reg;
        if (rd_en) begin
            fwd_next = same;
            hit_next = valid_reg[rd_idx] || same;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            fwd_reg   <= fwd_next;
            hit_reg   <= hit_next;
        end
    end

    assign rd_rec = fwd_reg ? fwd_rec_reg : rd_data_reg;
    assign rd_hit = hit_reg;

    a_fwd_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg |-> hit_reg)
        else $error("forwarded read without hit");

    a_wr_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> valid_reg[$past(wr_idx)])
        else $error("written entry not marked valid");

endmodule

`default_nettype wire

>>> src/tscc_emit.sv
// Command sequencer: holds one compared record and issues its commands through an output register.
`default_nettype none

module tscc_emit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         xn,
    input  wire logic                         ld_valid,
    output logic                              ld_ready,
    input  wire tscc_pkg::rec_t               ld_rec,
    input  wire logic [tscc_pkg::MASK_W-1:0]  ld_mask,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output tscc_pkg::cmd_t                    m_cmd,
    output logic                              m_last
);

    logic e_valid_reg;
    logic e_valid_next;
    tscc_pkg::rec_t e_rec_reg;
    logic [tscc_pkg::MASK_W-1:0] e_mask_reg;
    logic [tscc_pkg::MASK_W-1:0] e_mask_next;
    logic m_valid_reg;
    logic m_valid_next;
    tscc_pkg::cmd_t m_cmd_reg;
    logic m_last_reg;
    logic [tscc_pkg::MASK_W-1:0] pick_oh;
    logic [tscc_pkg::MASK_W-1:0] rest_mask;
    tscc_pkg::cmd_sel_t pick_sel;
    logic out_load;
    logic pick_last;
    logic ld_take;

    always_comb begin
        pick_oh  = e_mask_reg & (~e_mask_reg + tscc_pkg::MASK_W'(1));
        pick_sel = tscc_pkg::SEL_SPEED;
        for (int i = 0; i < tscc_pkg::MASK_W; i++) begin
            if (pick_oh[i]) begin
                pick_sel = tscc_pkg::cmd_sel_t'(3'(i));
            end
        end
        rest_mask = e_mask_reg & ~pick_oh;
        pick_last = (rest_mask == '0);
    end

    assign out_load = e_valid_reg && (!m_valid_reg || m_ready);
    assign ld_ready = !e_valid_reg || (out_load && pick_last);
    assign ld_take  = ld_valid && ld_ready;

    always_comb begin
        e_valid_next = e_valid_reg;
        e_mask_next  = e_mask_reg;
        if (ld_take) begin
            e_valid_next = 1'b1;
            e_mask_next  = ld_mask;
        end else if (out_load) begin
            e_valid_next = !pick_last;
            e_mask_next  = rest_mask;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_mask_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            e_valid_reg <= e_valid_next;
            e_mask_reg  <= e_mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_take) begin
            e_rec_reg <= ld_rec;
        end
        if (out_load) begin
            m_cmd_reg  <= tscc_pkg::build_cmd(pick_sel, e_rec_reg, xn);
            m_last_reg <= pick_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_cmd   = m_cmd_reg;
    assign m_last  = m_last_reg;

    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg |-> (e_mask_reg != '0))
        else $error("pending record with empty command mask");

    a_ld_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (ld_valid && ld_ready) |-> (ld_mask != '0))
        else $error("record loaded with no commands");

endmodule

`default_nettype wire

>>> src/throttle_status_to_cab_commands_core.sv
// Top level: status intake, address translation, cache compare and command output.
// An item moves through the intake register, the sequencer and the output register.
// Throughput: one command per cycle while m_ready is high; an item with n commands
// (1 to 6) holds the sequencer until the next item loads as its last command issues.
// Cache lookup uses one synchronous memory read port with forwarding of the write
// that retires the previous item. Reset clears all entry valid bits at once, no sweep.
`default_nettype none

module throttle_status_to_cab_commands_core #(
    parameter int THROTTLE_ENTRIES = tscc_pkg::THROTTLE_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_throttle_id,
    input  wire logic [15:0] s_loco_raw,
    input  wire logic [7:0]  s_speed_dir,
    input  wire logic [28:0] s_function_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_byte0,
    output logic [7:0]       m_byte1,
    output logic [7:0]       m_byte2,
    output logic [7:0]       m_byte3,
    output logic [7:0]       m_byte4,
    output logic [2:0]       m_length,
    output logic             m_last
);

    localparam int IDX_W = $clog2(THROTTLE_ENTRIES);

    logic xn_reg;
    logic xn_next;
    logic [IDX_W-1:0] idx_lut [256];
    logic s_take;
    logic b_valid_reg;
    logic b_valid_next;
    logic [IDX_W-1:0] b_idx_reg;
    tscc_pkg::rec_t b_rec_reg;
    tscc_pkg::rec_t c_rec;
    logic c_hit;
    logic b_to_e;
    logic e_ready;
    logic addr_chg;
    logic sd_chg;
    logic [4:0] grp_chg;
    logic any_chg;
    logic [tscc_pkg::MASK_W-1:0] b_mask;
    tscc_pkg::cmd_t m_cmd;

    for (genvar i = 0; i < 256; i++) begin : g_idx_lut
        assign idx_lut[i] = IDX_W'(i % THROTTLE_ENTRIES);
    end

    assign cfg_ready = 1'b1;
    assign xn_next   = (cfg_valid && cfg_ready) ? cfg_data : xn_reg;

    assign b_to_e  = b_valid_reg && e_ready;
    assign s_ready = !b_valid_reg || b_to_e;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (s_take) begin
            b_valid_next = 1'b1;
        end else if (b_to_e) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xn_reg      <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            xn_reg      <= xn_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            b_idx_reg <= idx_lut[s_throttle_id];
            b_rec_reg <= tscc_pkg::make_rec(s_loco_raw, s_speed_dir, s_function_bits, xn_reg);
        end
    end

    tscc_cache #(
        .THROTTLE_ENTRIES(THROTTLE_ENTRIES)
    ) u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_take),
        .rd_idx  (idx_lut[s_throttle_id]),
        .rd_rec  (c_rec),
        .rd_hit  (c_hit),
        .wr_en   (b_to_e),
        .wr_idx  (b_idx_reg),
        .wr_rec  (b_rec_reg)
    );

    always_comb begin
        addr_chg   = !c_hit || (c_rec.addr != b_rec_reg.addr);
        sd_chg     = !c_hit || (c_rec.sd != b_rec_reg.sd);
        grp_chg[0] = !c_hit || (c_rec.g1 != b_rec_reg.g1);
        grp_chg[1] = !c_hit || (c_rec.g2 != b_rec_reg.g2);
        grp_chg[2] = !c_hit || (c_rec.g3 != b_rec_reg.g3);
        grp_chg[3] = !c_hit || (c_rec.g4 != b_rec_reg.g4);
        grp_chg[4] = !c_hit || (c_rec.g5 != b_rec_reg.g5);
        any_chg    = addr_chg || sd_chg || (grp_chg != 5'd0);
        b_mask[0]  = addr_chg || sd_chg || !any_chg;
        for (int g = 0; g < 5; g++) begin
            b_mask[g+1] = addr_chg || grp_chg[g];
        end
    end

    tscc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .xn       (xn_reg),
        .ld_valid (b_valid_reg),
        .ld_ready (e_ready),
        .ld_rec   (b_rec_reg),
        .ld_mask  (b_mask),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_cmd    (m_cmd),
        .m_last   (m_last)
    );

    assign m_byte0  = m_cmd.b0;
    assign m_byte1  = m_cmd.b1;
    assign m_byte2  = m_cmd.b2;
    assign m_byte3  = m_cmd.b3;
    assign m_byte4  = m_cmd.b4;
    assign m_length = m_cmd.len;

    a_miss_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !c_hit) |-> (b_mask == '1))
        else $error("cache miss did not select every command");

endmodule

`default_nettype wire
